@@ hdl/rsz_pkg.sv @@
// Package for the bilinear RGB resize block.
// Holds the configuration record, register indexes, sequencer states and
// fixed arithmetic widths; it depends on nothing else.
package rsz_pkg;

  localparam int MAX_WIDTH_DEF = 512;
  localparam int MAX_ROWS_DEF  = 512;

  localparam int CFG_DATA_W = 25;
  localparam int WGT_W      = 15;
  localparam int ACC_W      = 22;
  localparam int FRAC_SH    = 14;
  localparam int NUM_TAPS   = 4;
  localparam int NUM_CHAN   = 3;

  localparam logic [2:0] REG_IN_WIDTH     = 3'd0;
  localparam logic [2:0] REG_IN_ROWS      = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH    = 3'd2;
  localparam logic [2:0] REG_OUT_ROWS     = 3'd3;
  localparam logic [2:0] REG_X_STEP       = 3'd4;
  localparam logic [2:0] REG_Y_STEP       = 3'd5;
  localparam logic [2:0] REG_IN_TILE_ROW  = 3'd6;
  localparam logic [2:0] REG_OUT_TILE_ROW = 3'd7;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef struct packed {
    logic [9:0]  in_width;
    logic [9:0]  in_rows;
    logic [9:0]  out_width;
    logic [9:0]  out_rows;
    logic [24:0] x_step;
    logic [24:0] y_step;
    logic [8:0]  in_tile_row;
    logic [8:0]  out_tile_row;
  } rsz_cfg_t;

  typedef struct packed {
    logic clr;
    logic en;
  } rsz_lane_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CLAMP,
    S_PREP,
    S_READ,
    S_DRAIN
  } rsz_state_t;

endpackage

@@ hdl/rsz_coord.sv @@
// Coordinate unit of the resize block: source positions, clamped neighbour
// addresses and combined bilinear weights, over three register stages.
// Depends on rsz_pkg.
module rsz_coord import rsz_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  localparam int COL_W    = $clog2(MAX_WIDTH),
  localparam int ROW_W    = $clog2(MAX_ROWS),
  localparam int ADDR_W   = $clog2(MAX_WIDTH * MAX_ROWS)
) (
  input  logic              clk,
  input  rsz_cfg_t          cfg,
  input  logic [8:0]        item_col,
  input  logic [8:0]        item_row,
  output logic [ADDR_W-1:0] tap_addr [NUM_TAPS],
  output logic [WGT_W-1:0]  tap_wgt [NUM_TAPS]
);

  logic [33:0]       xpos_r;
  logic [34:0]       ypos_r;
  logic [9:0]        yidx;
  logic [COL_W-1:0]  wm1, x0_nxt, x1_nxt, x0_r, x1_r;
  logic [ROW_W-1:0]  hm1, y0_nxt, y1_nxt, y0_r, y1_r;
  logic [17:0]       xi;
  logic [18:0]       yi, yrel;
  logic [6:0]        ww2_r, hw2_r;
  logic [7:0]        ww1, ww2, hw1, hw2;
  logic [ADDR_W-1:0] base0, base1;

  assign yidx = 10'(cfg.out_tile_row) + 10'(item_row);

  always_ff @(posedge clk) begin
    xpos_r <= 34'(item_col) * 34'(cfg.x_step);
    ypos_r <= 35'(yidx) * 35'(cfg.y_step);
  end

  assign xi   = xpos_r[33:16];
  assign yi   = ypos_r[34:16];
  assign yrel = yi - 19'(cfg.in_tile_row);

  always_comb begin
    if (cfg.in_width == 10'd0) begin
      wm1 = '0;
    end else if (32'(cfg.in_width) > MAX_WIDTH) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(cfg.in_width - 10'd1);
    end
    if (cfg.in_rows == 10'd0) begin
      hm1 = '0;
    end else if (32'(cfg.in_rows) > MAX_ROWS) begin
      hm1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      hm1 = ROW_W'(cfg.in_rows - 10'd1);
    end

    if (32'(xi) > 32'(wm1)) begin
      x0_nxt = wm1;
    end else begin
      x0_nxt = COL_W'(xi);
    end
    x1_nxt = (x0_nxt == wm1) ? wm1 : x0_nxt + COL_W'(1);

    if (yi < 19'(cfg.in_tile_row)) begin
      y0_nxt = '0;
    end else if (32'(yrel) > 32'(hm1)) begin
      y0_nxt = hm1;
    end else begin
      y0_nxt = ROW_W'(yrel);
    end
    y1_nxt = (y0_nxt == hm1) ? hm1 : y0_nxt + ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    x0_r  <= x0_nxt;
    x1_r  <= x1_nxt;
    y0_r  <= y0_nxt;
    y1_r  <= y1_nxt;
    ww2_r <= xpos_r[15:9];
    hw2_r <= ypos_r[15:9];
  end

  assign ww2   = {1'b0, ww2_r};
  assign hw2   = {1'b0, hw2_r};
  assign ww1   = 8'd128 - ww2;
  assign hw1   = 8'd128 - hw2;
  assign base0 = ADDR_W'(ADDR_W'(y0_r) * ADDR_W'(MAX_WIDTH));
  assign base1 = ADDR_W'(ADDR_W'(y1_r) * ADDR_W'(MAX_WIDTH));

  // Tap order: floor pixel, the one below, the one to the right, diagonal.
  always_ff @(posedge clk) begin
    tap_addr[0] <= base0 + ADDR_W'(x0_r);
    tap_addr[1] <= base1 + ADDR_W'(x0_r);
    tap_addr[2] <= base0 + ADDR_W'(x1_r);
    tap_addr[3] <= base1 + ADDR_W'(x1_r);
    tap_wgt[0]  <= WGT_W'(16'(hw1) * 16'(ww1));
    tap_wgt[1]  <= WGT_W'(16'(hw2) * 16'(ww1));
    tap_wgt[2]  <= WGT_W'(16'(hw1) * 16'(ww2));
    tap_wgt[3]  <= WGT_W'(16'(hw2) * 16'(ww2));
  end

endmodule

@@ hdl/rsz_lane.sv @@
// One channel lane of the resize block: multiplies each fetched channel
// byte by its tap weight and accumulates the sum. Depends on rsz_pkg.
module rsz_lane import rsz_pkg::*; (
  input  logic             clk,
  input  rsz_lane_ctl_t    ctl,
  input  logic [7:0]       pix,
  input  logic [WGT_W-1:0] wgt,
  output logic [ACC_W-1:0] acc_sum
);

  logic [ACC_W-1:0] acc_r;

  assign acc_sum = acc_r + ACC_W'(ACC_W'(pix) * ACC_W'(wgt));

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.en) begin
      acc_r <= acc_sum;
    end
  end

endmodule

@@ hdl/bilinear_resize_rgb.sv @@
// Top level of the bilinear RGB resize block: configuration registers,
// pixel store, sequencer, three channel lanes and the result register.
// Depends on rsz_pkg, rsz_coord and rsz_lane.
//
// A load transfer writes one pixel into the store if its row and column lie
// inside it; busy stays low. A compute transfer raises busy and its result
// appears on the out_ ports with out_valid high for one cycle, after the
// position multipliers, the clamping and address stages, the four neighbour
// reads through the single store port and the final accumulation, or, when
// the request lies outside the output size, once the range check in S_MUL is
// registered. The result cannot be held off, so it must be taken in the cycle
// it is shown. The store is not cleared after reset: only pixels that have
// been loaded may be used.
module bilinear_resize_rgb import rsz_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_ROWS  = MAX_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic [8:0]            in_load_row,
  input  logic [8:0]            in_load_col,
  input  logic [7:0]            in_chan0,
  input  logic [7:0]            in_chan1,
  input  logic [7:0]            in_chan2,
  input  logic [8:0]            in_out_col,
  input  logic [8:0]            in_out_row,
  output logic                  out_valid,
  output logic [7:0]            out_res_chan0,
  output logic [7:0]            out_res_chan1,
  output logic [7:0]            out_res_chan2,
  output logic                  out_range_error,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_ROWS);
  localparam int DEPTH  = MAX_WIDTH * MAX_ROWS;

  rsz_cfg_t      cfg_r;
  rsz_state_t    state_r, state_nxt;
  logic [1:0]    rd_cnt_r, rd_cnt_nxt, rd_sel_r;
  logic          rd_vld_r;
  logic [8:0]    col_r, row_r;
  logic          out_valid_r, out_valid_nxt, out_err_r, out_err_nxt;
  logic [7:0]    out_res_r [NUM_CHAN];
  logic [7:0]    out_res_nxt [NUM_CHAN];
  logic          acc_in, ld_acc, ld_ok, mem_we, range_err;
  logic [ADDR_W-1:0] wr_addr, mem_addr;
  logic [ADDR_W-1:0] tap_addr [NUM_TAPS];
  logic [WGT_W-1:0]  tap_wgt [NUM_TAPS];
  logic [23:0]   mem [DEPTH];
  logic [23:0]   rd_data_r;
  logic [ACC_W-1:0] acc_sum [NUM_CHAN];
  rsz_lane_ctl_t lane_ctl;

  assign busy   = (state_r != S_IDLE);
  assign acc_in = start && !busy;
  assign ld_acc = acc_in && (in_cmd == CMD_LOAD);
  assign ld_ok  = (32'(in_load_row) < MAX_ROWS) && (32'(in_load_col) < MAX_WIDTH);
  assign mem_we = ld_acc && ld_ok;
  assign wr_addr = ADDR_W'(ADDR_W'(in_load_row) * ADDR_W'(MAX_WIDTH))
                 + ADDR_W'(in_load_col);
  assign mem_addr = ld_acc ? wr_addr : tap_addr[rd_cnt_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_width     <= 10'd512;
      cfg_r.in_rows      <= 10'd512;
      cfg_r.out_width    <= 10'd112;
      cfg_r.out_rows     <= 10'd112;
      cfg_r.x_step       <= '0;
      cfg_r.y_step       <= '0;
      cfg_r.in_tile_row  <= '0;
      cfg_r.out_tile_row <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_WIDTH:     cfg_r.in_width     <= cfg_data[9:0];
        REG_IN_ROWS:      cfg_r.in_rows      <= cfg_data[9:0];
        REG_OUT_WIDTH:    cfg_r.out_width    <= cfg_data[9:0];
        REG_OUT_ROWS:     cfg_r.out_rows     <= cfg_data[9:0];
        REG_X_STEP:       cfg_r.x_step       <= cfg_data[24:0];
        REG_Y_STEP:       cfg_r.y_step       <= cfg_data[24:0];
        REG_IN_TILE_ROW:  cfg_r.in_tile_row  <= cfg_data[8:0];
        REG_OUT_TILE_ROW: cfg_r.out_tile_row <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      col_r <= in_out_col;
      row_r <= in_out_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {in_chan2, in_chan1, in_chan0};
    end
    rd_data_r <= mem[mem_addr];
  end

  rsz_coord #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_ROWS  (MAX_ROWS)
  ) u_coord (
    .clk      (clk),
    .cfg      (cfg_r),
    .item_col (col_r),
    .item_row (row_r),
    .tap_addr (tap_addr),
    .tap_wgt  (tap_wgt)
  );

  for (genvar gi = 0; gi < NUM_CHAN; gi++) begin : g_lane
    rsz_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .pix     (rd_data_r[8*gi +: 8]),
      .wgt     (tap_wgt[rd_sel_r]),
      .acc_sum (acc_sum[gi])
    );
  end

  assign range_err = ({1'b0, col_r} >= cfg_r.out_width) || ({1'b0, row_r} >= cfg_r.out_rows);

  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    out_valid_nxt = 1'b0;
    out_err_nxt   = out_err_r;
    out_res_nxt   = out_res_r;
    lane_ctl.clr  = 1'b0;
    lane_ctl.en   = rd_vld_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_in && (in_cmd == CMD_COMPUTE)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (range_err) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = 1'b1;
          for (int i = 0; i < NUM_CHAN; i++) begin
            out_res_nxt[i] = '0;
          end
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        state_nxt = S_PREP;
      end
      S_PREP: begin
        lane_ctl.clr = 1'b1;
        rd_cnt_nxt   = '0;
        state_nxt    = S_READ;
      end
      S_READ: begin
        rd_cnt_nxt = rd_cnt_r + 2'd1;
        if (rd_cnt_r == 2'(NUM_TAPS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        out_valid_nxt = 1'b1;
        out_err_nxt   = 1'b0;
        for (int i = 0; i < NUM_CHAN; i++) begin
          out_res_nxt[i] = acc_sum[i][FRAC_SH +: 8];
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rd_vld_r    <= (state_r == S_READ);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_sel_r    <= rd_cnt_r;
    out_err_r   <= out_err_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_res_chan0   = out_res_r[0];
  assign out_res_chan1   = out_res_r[1];
  assign out_res_chan2   = out_res_r[2];
  assign out_range_error = out_err_r;

`ifndef NO_ASSERTIONS
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while the sequencer is still busy");

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_COMPUTE) |=> busy)
    else $error("compute transfer did not start the sequencer");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_LOAD) |=> !busy && !out_valid)
    else $error("load transfer disturbed the sequencer");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |->
      (out_res_chan0 == 8'd0 && out_res_chan1 == 8'd0 && out_res_chan2 == 8'd0))
    else $error("range error result carries non-zero channels");
`endif

endmodule
